// ===== rtl/bme_pkg.sv =====
// package: types, codes and helper functions of the byte machine execute unit
`default_nettype none

package bme_pkg;

    localparam int unsigned MEM_WORDS_DEF = 64;
    localparam int unsigned REG_COUNT_DEF = 8;

    // instruction codes
    localparam logic [4:0] FN_MOVIMM   = 5'd0;
    localparam logic [4:0] FN_MOVREG   = 5'd1;
    localparam logic [4:0] FN_LOADIND  = 5'd2;
    localparam logic [4:0] FN_LOADDIR  = 5'd3;
    localparam logic [4:0] FN_STOREIND = 5'd4;
    localparam logic [4:0] FN_STOREDIR = 5'd5;
    localparam logic [4:0] FN_ADD      = 5'd6;
    localparam logic [4:0] FN_SUB      = 5'd7;
    localparam logic [4:0] FN_MUL      = 5'd8;
    localparam logic [4:0] FN_DIV      = 5'd9;
    localparam logic [4:0] FN_INC      = 5'd10;
    localparam logic [4:0] FN_DEC      = 5'd11;
    localparam logic [4:0] FN_SHL      = 5'd12;
    localparam logic [4:0] FN_SHR      = 5'd13;
    localparam logic [4:0] FN_ROL      = 5'd14;
    localparam logic [4:0] FN_ROR      = 5'd15;
    localparam logic [4:0] FN_READ     = 5'd16;

    localparam logic signed [16:0] EXACT_MAX = 17'sd127;
    localparam logic signed [16:0] EXACT_MIN = -17'sd128;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDREG,
        ST_RDMEM,
        ST_DIV,
        ST_DIVFIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic underflow;
        logic overflow;
        logic carry;
        logic zero;
    } flags_t;

    typedef struct packed {
        logic [7:0] value;
        flags_t     flags;
    } res_t;

    // register index modulo the register count, two compare-subtract steps
    function automatic logic [2:0] reg_mod(logic [2:0] r, int unsigned n);
        logic [4:0] v;
        logic [4:0] m;
        v = {2'b00, r};
        for (int k = 1; k >= 0; k--) begin
            m = 5'(n) << k;
            if (v >= m) v = v - m;
        end
        return v[2:0];
    endfunction

    // byte address modulo the memory size, restoring compare-subtract
    function automatic logic [8:0] mem_mod(logic [7:0] a, int unsigned n);
        logic [12:0] v;
        logic [12:0] m;
        v = {5'b0, a};
        for (int k = 4; k >= 0; k--) begin
            m = 13'(n) << k;
            if (v >= m) v = v - m;
        end
        return v[8:0];
    endfunction

    // moved byte: only zero can be set
    function automatic res_t move_result(logic [7:0] b);
        res_t r;
        r.value           = b;
        r.flags.underflow = 1'b0;
        r.flags.overflow  = 1'b0;
        r.flags.carry     = 1'b0;
        r.flags.zero      = (b == 8'h00);
        return r;
    endfunction

    // flags from the untruncated result
    function automatic res_t arith_result(logic signed [16:0] exact);
        res_t r;
        r.value           = exact[7:0];
        r.flags.zero      = (exact[7:0] == 8'h00);
        r.flags.overflow  = (exact > EXACT_MAX);
        r.flags.underflow = (exact < EXACT_MIN);
        r.flags.carry     = r.flags.overflow | r.flags.underflow;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bme_if.sv =====
// interfaces: instruction word channel and result word channel
`default_nettype none

interface bme_cmd_if;
    logic              valid;
    logic              ready;
    logic [4:0]        func;
    logic [2:0]        src_reg;
    logic [2:0]        dst_reg;
    logic              use_imm;
    logic signed [7:0] imm;
    logic [5:0]        addr;

    modport source (output valid, func, src_reg, dst_reg, use_imm, imm, addr, input ready);
    modport sink   (input valid, func, src_reg, dst_reg, use_imm, imm, addr, output ready);
endinterface

interface bme_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] value;
    logic              zero_flag;
    logic              carry_flag;
    logic              overflow_flag;
    logic              underflow_flag;
    logic              error;

    modport source (output valid, value, zero_flag, carry_flag, overflow_flag,
                    underflow_flag, error, input ready);
    modport sink   (input valid, value, zero_flag, carry_flag, overflow_flag,
                    underflow_flag, error, output ready);
endinterface

`default_nettype wire

// ===== rtl/byte_machine_execute_unit.sv =====
// top level: sequenced execute unit with register file and data memory
//
//  channel  dir  word contents
//  cmd      in   func, src_reg, dst_reg, use_imm, imm, addr
//  rsp      out  value, zero/carry/overflow/underflow flags, error
//
// one instruction at a time: accept, register file read, execute, commit
// moves, stores, arithmetic, shifts, read and divide by zero pass register read, then finish;
// loads add a data memory read state; divide adds 8 steps of the radix-2 divider and a final state
// the result sits in an output register; a new word is taken while it waits,
// commit of the next result holds until the output register is free
// reset clears register and memory valid bits at once, no clearing pass
`default_nettype none

module byte_machine_execute_unit
    import bme_pkg::*;
#(
    parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
    parameter int unsigned REG_COUNT = REG_COUNT_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    bme_cmd_if.sink   cmd,
    bme_rsp_if.source rsp
);

    localparam int unsigned RIDX_W  = $clog2(REG_COUNT);
    localparam int unsigned MADDR_W = $clog2(MEM_WORDS);

    state_t state_reg, state_next;

    // latched instruction
    logic [4:0]        func_reg;
    logic [RIDX_W-1:0] d_idx_reg;
    logic              use_imm_reg;
    logic signed [7:0] imm_reg;
    logic [5:0]        addr_reg;

    // register file and data memory
    logic [7:0]           rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_vld_reg;
    logic [7:0]           data_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] mem_vld_reg;

    logic [7:0] rf_a_reg, rf_b_reg, mem_rd_reg;
    logic       rf_a_vld_reg, rf_b_vld_reg, mem_rd_vld_reg;

    // pending result and write-back
    logic [7:0]         res_value_reg, res_value_next;
    flags_t             res_flags_reg, res_flags_next;
    logic               res_err_reg, res_err_next;
    logic               reg_we_reg, reg_we_next;
    logic               mem_we_reg, mem_we_next;
    logic [MADDR_W-1:0] mem_addr_reg, mem_addr_next;
    logic               mem_re;

    // divider
    logic [7:0] rem_reg, rem_next;
    logic [7:0] quo_reg, quo_next;
    logic [7:0] dvs_reg, dvs_next;
    logic       neg_reg, neg_next;
    logic [2:0] cnt_reg, cnt_next;

    flags_t flags_reg, flags_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_value_reg;
    flags_t     out_flags_reg;
    logic       out_err_reg;

    logic              in_acc, commit;
    logic [RIDX_W-1:0] s_idx, d_idx;
    logic signed [7:0] op_s, op_d, op_b;
    logic signed [16:0] add_x, sub_x, inc_x, dec_x, quo_x, div_x;
    logic signed [15:0] prod;
    logic [7:0]         dvd_mag, dvs_mag, mv_byte;
    logic [8:0]         trial;
    res_t               res_c;

    assign in_acc = cmd.valid & cmd.ready;
    assign s_idx  = RIDX_W'(reg_mod(cmd.src_reg, REG_COUNT));
    assign d_idx  = RIDX_W'(reg_mod(cmd.dst_reg, REG_COUNT));

    // unwritten entries read as zero
    assign op_s = rf_a_vld_reg ? rf_a_reg : 8'h00;
    assign op_d = rf_b_vld_reg ? rf_b_reg : 8'h00;
    assign op_b = use_imm_reg ? imm_reg : op_s;

    assign add_x = 17'(op_d) + 17'(op_b);
    assign sub_x = 17'(op_d) - 17'(op_b);
    assign inc_x = 17'(op_d) + 17'sd1;
    assign dec_x = 17'(op_d) - 17'sd1;
    assign prod  = op_d * op_b;

    assign dvd_mag = op_d[7] ? 8'(-op_d) : 8'(op_d);
    assign dvs_mag = op_b[7] ? 8'(-op_b) : 8'(op_b);
    assign trial   = {rem_reg, quo_reg[7]};
    assign quo_x   = signed'(17'(quo_reg));
    assign div_x   = neg_reg ? -quo_x : quo_x;
    assign mv_byte = mem_rd_vld_reg ? mem_rd_reg : 8'h00;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.ready      = 1'b0;
        commit         = 1'b0;
        mem_re         = 1'b0;
        res_c          = move_result(8'h00);
        res_value_next = res_value_reg;
        res_flags_next = res_flags_reg;
        res_err_next   = res_err_reg;
        reg_we_next    = reg_we_reg;
        mem_we_next    = mem_we_reg;
        mem_addr_next  = mem_addr_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                    state_next = ST_RDREG;
            end
            ST_RDREG:
            begin
                state_next     = ST_FINISH;
                res_err_next   = 1'b0;
                reg_we_next    = 1'b0;
                mem_we_next    = 1'b0;
                res_value_next = 8'h00;
                res_flags_next = flags_reg;
                unique case (func_reg)
                    FN_MOVIMM, FN_MOVREG:
                    begin
                        res_c          = move_result(func_reg == FN_MOVIMM ? imm_reg : op_s);
                        res_value_next = res_c.value;
                        res_flags_next = res_c.flags;
                        reg_we_next    = 1'b1;
                    end
                    FN_LOADIND, FN_LOADDIR:
                    begin
                        mem_addr_next = (func_reg == FN_LOADIND) ?
                                        MADDR_W'(mem_mod(op_s, MEM_WORDS)) :
                                        MADDR_W'(mem_mod({2'b00, addr_reg}, MEM_WORDS));
                        mem_re        = 1'b1;
                        state_next    = ST_RDMEM;
                    end
                    FN_STOREIND, FN_STOREDIR:
                    begin
                        mem_addr_next  = (func_reg == FN_STOREIND) ?
                                         MADDR_W'(mem_mod(op_d, MEM_WORDS)) :
                                         MADDR_W'(mem_mod({2'b00, addr_reg}, MEM_WORDS));
                        res_c          = move_result(op_s);
                        res_value_next = res_c.value;
                        res_flags_next = res_c.flags;
                        mem_we_next    = 1'b1;
                    end
                    FN_ADD, FN_SUB, FN_MUL, FN_INC, FN_DEC:
                    begin
                        priority case (func_reg)
                            FN_ADD:  res_c = arith_result(add_x);
                            FN_SUB:  res_c = arith_result(sub_x);
                            FN_MUL:  res_c = arith_result(17'(prod));
                            FN_INC:  res_c = arith_result(inc_x);
                            default: res_c = arith_result(dec_x);
                        endcase
                        res_value_next = res_c.value;
                        res_flags_next = res_c.flags;
                        reg_we_next    = 1'b1;
                    end
                    FN_DIV:
                    begin
                        if (op_b == 8'sd0)
                            res_err_next = 1'b1;
                        else
                        begin
                            rem_next   = 8'h00;
                            quo_next   = dvd_mag;
                            dvs_next   = dvs_mag;
                            neg_next   = op_d[7] ^ op_b[7];
                            cnt_next   = 3'd0;
                            state_next = ST_DIV;
                        end
                    end
                    FN_SHL, FN_SHR, FN_ROL, FN_ROR:
                    begin
                        priority case (func_reg)
                            FN_SHL:  res_value_next = {op_d[6:0], 1'b0};
                            FN_SHR:  res_value_next = {1'b0, op_d[7:1]};
                            FN_ROL:  res_value_next = {op_d[6:0], op_d[7]};
                            default: res_value_next = {op_d[0], op_d[7:1]};
                        endcase
                        res_flags_next.underflow = 1'b0;
                        res_flags_next.overflow  = 1'b0;
                        res_flags_next.carry     = (func_reg == FN_SHL || func_reg == FN_ROL) ?
                                                   op_d[7] : op_d[0];
                        res_flags_next.zero      = (res_value_next == 8'h00);
                        reg_we_next              = 1'b1;
                    end
                    FN_READ:
                        res_value_next = op_s;
                    default:
                        res_value_next = 8'h00;
                endcase
            end
            ST_RDMEM:
            begin
                res_c          = move_result(mv_byte);
                res_value_next = res_c.value;
                res_flags_next = res_c.flags;
                reg_we_next    = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = 8'(trial - {1'b0, dvs_reg});
                    quo_next = {quo_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[7:0];
                    quo_next = {quo_reg[6:0], 1'b0};
                end
                cnt_next = cnt_reg + 3'd1;
                if (&cnt_reg)
                    state_next = ST_DIVFIN;
            end
            ST_DIVFIN:
            begin
                res_c          = arith_result(div_x);
                res_value_next = res_c.value;
                res_flags_next = res_c.flags;
                reg_we_next    = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        flags_next = commit ? res_flags_reg : flags_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
            rf_vld_reg    <= '0;
            mem_vld_reg   <= '0;
            reg_we_reg    <= 1'b0;
            mem_we_reg    <= 1'b0;
            res_err_reg   <= 1'b0;
            cnt_reg       <= 3'd0;
        end
        else
        begin
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
            reg_we_reg    <= reg_we_next;
            mem_we_reg    <= mem_we_next;
            res_err_reg   <= res_err_next;
            cnt_reg       <= cnt_next;
            if (commit && reg_we_reg)
                rf_vld_reg[d_idx_reg] <= 1'b1;
            if (commit && mem_we_reg)
                mem_vld_reg[mem_addr_reg] <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        res_value_reg <= res_value_next;
        res_flags_reg <= res_flags_next;
        mem_addr_reg  <= mem_addr_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dvs_reg       <= dvs_next;
        neg_reg       <= neg_next;
        if (in_acc)
        begin
            func_reg    <= cmd.func;
            d_idx_reg   <= d_idx;
            use_imm_reg <= cmd.use_imm;
            imm_reg     <= cmd.imm;
            addr_reg    <= cmd.addr;
        end
        if (commit)
        begin
            out_value_reg <= res_value_reg;
            out_flags_reg <= res_flags_reg;
            out_err_reg   <= res_err_reg;
        end
    end

    // register file: two read ports, one write port
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rf_a_reg     <= rf_mem[s_idx];
            rf_b_reg     <= rf_mem[d_idx];
            rf_a_vld_reg <= rf_vld_reg[s_idx];
            rf_b_vld_reg <= rf_vld_reg[d_idx];
        end
        if (commit && reg_we_reg)
            rf_mem[d_idx_reg] <= res_value_reg;
    end

    // data memory: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_rd_reg     <= data_mem[mem_addr_next];
            mem_rd_vld_reg <= mem_vld_reg[mem_addr_next];
        end
        if (commit && mem_we_reg)
            data_mem[mem_addr_reg] <= res_value_reg;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.value          = out_value_reg;
    assign rsp.zero_flag      = out_flags_reg.zero;
    assign rsp.carry_flag     = out_flags_reg.carry;
    assign rsp.overflow_flag  = out_flags_reg.overflow;
    assign rsp.underflow_flag = out_flags_reg.underflow;
    assign rsp.error          = out_err_reg;

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_RDREG)
        else $error("accepted word did not move to register read");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == 3'd7) |=> state_reg == ST_DIVFIN)
        else $error("divider did not finish after eight steps");

    a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && res_err_reg) |-> (!reg_we_reg && !mem_we_reg))
        else $error("divide by zero would write state");

    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared without a commit");

endmodule

`default_nettype wire
